@@ hw/rtl/ssl_pkg.sv @@
// Shared types and constants for the sorted set linked table.
// Used by the channel payloads, the compare unit, the store and the top level.
// No dependencies.
package ssl_pkg;

   localparam int DEFAULT_CAPACITY = 64;
   localparam int VALUE_WIDTH      = 32;
   localparam int MODE_WIDTH       = 2;
   localparam int STATUS_WIDTH     = 2;
   localparam int COUNT_WIDTH      = 7;

   // request operations
   localparam logic [MODE_WIDTH-1:0] MODE_ADD    = 2'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_REMOVE = 2'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_SEARCH = 2'd2;

   // response status codes
   localparam logic [STATUS_WIDTH-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_MISS = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_FULL = 2'd2;

   typedef struct packed {
      logic [MODE_WIDTH-1:0]         mode;
      logic signed [VALUE_WIDTH-1:0] value;
   } req_payload_type;

   typedef struct packed {
      logic [STATUS_WIDTH-1:0] status;
      logic [COUNT_WIDTH-1:0]  count;
   } rsp_payload_type;

   // store port controls
   typedef struct packed {
      logic rd_en;
      logic val_we;
      logic link_we;
   } store_ctl_type;

   // compare unit result
   typedef struct packed {
      logic equal;
      logic precedes;
   } cmp_result_type;

endpackage

@@ hw/rtl/ssl_chan_if.sv @@
// Valid/ready channel carrying one payload per transfer.
// Payload type is set per instance; no package dependency.
interface ssl_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ hw/rtl/ssl_cmp.sv @@
// Shared compare unit: equality and order test of a stored value against the key.
// Depends on ssl_pkg.
module ssl_cmp (
   input  logic signed [ssl_pkg::VALUE_WIDTH-1:0] stored,
   input  logic signed [ssl_pkg::VALUE_WIDTH-1:0] key,
   input  logic                                   descending,
   output ssl_pkg::cmp_result_type                result
);
   import ssl_pkg::*;

   always_comb begin
      result.equal    = (stored == key);
      // stored value may stay ahead of the key
      result.precedes = descending ? (stored >= key) : (stored <= key);
   end

endmodule

@@ hw/rtl/ssl_store.sv @@
// Value store and link store, one write and one registered read port each.
// Depends on ssl_pkg.
module ssl_store #(
   parameter int CAPACITY = ssl_pkg::DEFAULT_CAPACITY,
   localparam int IW = $clog2(CAPACITY + 1),
   localparam int AW = $clog2(CAPACITY)
) (
   input  logic                                   clock,
   input  ssl_pkg::store_ctl_type                 ctl,
   input  logic [AW-1:0]                          rd_addr,
   input  logic [AW-1:0]                          wr_addr,
   input  logic signed [ssl_pkg::VALUE_WIDTH-1:0] val_wdata,
   input  logic [IW-1:0]                          link_wdata,
   output logic signed [ssl_pkg::VALUE_WIDTH-1:0] val_rdata,
   output logic [IW-1:0]                          link_rdata
);
   import ssl_pkg::*;

   logic signed [VALUE_WIDTH-1:0] value_mem_ff [CAPACITY];
   logic [IW-1:0]                 link_mem_ff  [CAPACITY];
   logic signed [VALUE_WIDTH-1:0] val_rd_ff;
   logic [IW-1:0]                 link_rd_ff;

   always_ff @(posedge clock) begin
      if (ctl.val_we) begin
         value_mem_ff[wr_addr] <= val_wdata;
      end
      if (ctl.rd_en) begin
         val_rd_ff <= value_mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.link_we) begin
         link_mem_ff[wr_addr] <= link_wdata;
      end
      if (ctl.rd_en) begin
         link_rd_ff <= link_mem_ff[rd_addr];
      end
   end

   assign val_rdata  = val_rd_ff;
   assign link_rdata = link_rd_ff;

endmodule

@@ hw/rtl/sorted_set_linked_table.sv @@
// Top level of the sorted set linked table: sequencer, list and free-list heads.
// Depends on ssl_pkg, ssl_chan_if, ssl_cmp and ssl_store.
//
//   channel   direction  handshake               payload
//   req_chan  in         valid/ready transfer    mode, value
//   rsp_chan  out        valid/ready transfer    status, count
//   csr_*     in         write enable, no stall  order_descending
//
// Walk: one list entry is visited per cycle, the link read of one entry
//   giving the address of the next.
// Reset: untouched slots are tracked by a fill mark, so there is
//   no clearing pass over the link store.
// Stalls: a new request is taken while the previous result still waits;
//   the sequencer holds in its final step until the result register is free.
module sorted_set_linked_table #(
   parameter int CAPACITY = ssl_pkg::DEFAULT_CAPACITY
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_wr_en,
   input  logic          csr_wr_data,
   ssl_chan_if.sink      req_chan,
   ssl_chan_if.source    rsp_chan
);
   import ssl_pkg::*;

   localparam int IW = $clog2(CAPACITY + 1);
   localparam int AW = $clog2(CAPACITY);
   // null index: one past the last slot
   localparam logic [IW-1:0] NIL = IW'(CAPACITY);

   // sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_WALK = 3'd1;
   localparam logic [2:0] S_INS1 = 3'd2;
   localparam logic [2:0] S_INS2 = 3'd3;
   localparam logic [2:0] S_INS3 = 3'd4;
   localparam logic [2:0] S_REM1 = 3'd5;
   localparam logic [2:0] S_REM2 = 3'd6;
   localparam logic [2:0] S_DONE = 3'd7;

   logic [2:0]                    state_ff, state_in;
   logic [MODE_WIDTH-1:0]         mode_ff, mode_in;
   logic signed [VALUE_WIDTH-1:0] value_ff, value_in;
   logic [IW-1:0]                 cur_ff, cur_in;
   logic [IW-1:0]                 prev_ff, prev_in;
   logic [IW-1:0]                 next_ff, next_in;   // successor on remove, slot on add
   logic [IW-1:0]                 steps_ff, steps_in;
   logic [STATUS_WIDTH-1:0]       status_ff, status_in;
   logic [IW-1:0]                 list_head_ff, list_head_in;
   logic [IW-1:0]                 free_head_ff, free_head_in;
   logic [IW-1:0]                 held_ff, held_in;
   logic [IW-1:0]                 fill_ff, fill_in;   // slots at or above are untouched
   logic                          order_ff, order_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [STATUS_WIDTH-1:0]       rsp_status_ff, rsp_status_in;
   logic [COUNT_WIDTH-1:0]        rsp_count_ff, rsp_count_in;

   store_ctl_type                 st_ctl;
   logic [AW-1:0]                 st_rd_addr, st_wr_addr;
   logic signed [VALUE_WIDTH-1:0] st_val_wdata, st_val_rdata;
   logic [IW-1:0]                 st_link_wdata, st_link_rdata;
   cmp_result_type                cmp_res;

   logic                          req_take;
   logic [IW-1:0]                 link_next;
   logic                          bound_hit;
   logic                          keep_going;

   ssl_store #(
      .CAPACITY(CAPACITY)
   ) u_store (
      .clock      (clock),
      .ctl        (st_ctl),
      .rd_addr    (st_rd_addr),
      .wr_addr    (st_wr_addr),
      .val_wdata  (st_val_wdata),
      .link_wdata (st_link_wdata),
      .val_rdata  (st_val_rdata),
      .link_rdata (st_link_rdata)
   );

   // one comparator, reused for every entry of the walk
   ssl_cmp u_cmp (
      .stored     (st_val_rdata),
      .key        (value_ff),
      .descending (order_ff),
      .result     (cmp_res)
   );

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_take       = req_chan.valid && req_chan.ready;

   // out-of-range links read as null
   assign link_next = (st_link_rdata >= NIL) ? NIL : st_link_rdata;
   assign bound_hit = (steps_ff == NIL);

   // walk continues past the current entry
   always_comb begin
      if (mode_ff == MODE_ADD) begin
         keep_going = !cmp_res.equal && cmp_res.precedes && !bound_hit;
      end else begin
         keep_going = !cmp_res.equal && !bound_hit;
      end
   end

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      value_in      = value_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      next_in       = next_ff;
      steps_in      = steps_ff;
      status_in     = status_ff;
      list_head_in  = list_head_ff;
      free_head_in  = free_head_ff;
      held_in       = held_ff;
      fill_in       = fill_ff;
      order_in      = csr_wr_en ? csr_wr_data : order_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;

      st_ctl        = '0;
      st_rd_addr    = cur_ff[AW-1:0];
      st_wr_addr    = cur_ff[AW-1:0];
      st_val_wdata  = value_ff;
      st_link_wdata = free_head_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               mode_in  = req_chan.payload.mode;
               value_in = req_chan.payload.value;
               cur_in   = list_head_ff;
               prev_in  = NIL;
               steps_in = '0;
               if (req_chan.payload.mode != MODE_ADD &&
                   req_chan.payload.mode != MODE_REMOVE &&
                   req_chan.payload.mode != MODE_SEARCH) begin
                  // unused mode: answer a miss, touch nothing
                  status_in = STATUS_MISS;
                  state_in  = S_DONE;
               end else if (list_head_ff == NIL) begin
                  // empty list: only an add has work left
                  if (req_chan.payload.mode == MODE_ADD) begin
                     state_in = S_INS1;
                  end else begin
                     status_in = STATUS_MISS;
                     state_in  = S_DONE;
                  end
               end else begin
                  st_ctl.rd_en = 1'b1;
                  st_rd_addr   = list_head_ff[AW-1:0];
                  state_in     = S_WALK;
               end
            end
         end

         S_WALK: begin
            if (keep_going) begin
               // advance one entry; the link just read addresses the next
               prev_in  = cur_ff;
               cur_in   = link_next;
               steps_in = IW'(steps_ff + 1'b1);
               if (link_next == NIL) begin
                  if (mode_ff == MODE_ADD) begin
                     state_in = S_INS1;
                  end else begin
                     status_in = STATUS_MISS;
                     state_in  = S_DONE;
                  end
               end else begin
                  st_ctl.rd_en = 1'b1;
                  st_rd_addr   = link_next[AW-1:0];
               end
            end else begin
               unique case (mode_ff)
                  MODE_ADD: begin
                     if (cmp_res.equal) begin
                        status_in = STATUS_MISS;
                        state_in  = S_DONE;
                     end else begin
                        state_in = S_INS1;
                     end
                  end
                  MODE_REMOVE: begin
                     if (cmp_res.equal) begin
                        next_in  = link_next;
                        state_in = S_REM1;
                     end else begin
                        status_in = STATUS_MISS;
                        state_in  = S_DONE;
                     end
                  end
                  MODE_SEARCH: begin
                     status_in = (cmp_res.equal && !bound_hit) ? STATUS_OK : STATUS_MISS;
                     state_in  = S_DONE;
                  end
                  default: begin
                     status_in = STATUS_MISS;
                     state_in  = S_DONE;
                  end
               endcase
            end
         end

         S_INS1: begin
            if (free_head_ff == NIL) begin
               status_in = STATUS_FULL;
               state_in  = S_DONE;
            end else begin
               // fetch the link of the slot about to be taken
               st_ctl.rd_en = 1'b1;
               st_rd_addr   = free_head_ff[AW-1:0];
               state_in     = S_INS2;
            end
         end

         S_INS2: begin
            st_ctl.val_we  = 1'b1;
            st_ctl.link_we = 1'b1;
            st_wr_addr     = free_head_ff[AW-1:0];
            st_val_wdata   = value_ff;
            st_link_wdata  = cur_ff;
            next_in        = free_head_ff;
            if (free_head_ff >= fill_ff) begin
               // untouched slot: its free link is the following slot
               free_head_in = IW'(free_head_ff + 1'b1);
               fill_in      = IW'(free_head_ff + 1'b1);
            end else begin
               free_head_in = link_next;
            end
            state_in = S_INS3;
         end

         S_INS3: begin
            if (prev_ff == NIL) begin
               list_head_in = next_ff;
            end else begin
               st_ctl.link_we = 1'b1;
               st_wr_addr     = prev_ff[AW-1:0];
               st_link_wdata  = next_ff;
            end
            held_in   = IW'(held_ff + 1'b1);
            status_in = STATUS_OK;
            state_in  = S_DONE;
         end

         S_REM1: begin
            if (prev_ff == NIL) begin
               list_head_in = next_ff;
            end else begin
               st_ctl.link_we = 1'b1;
               st_wr_addr     = prev_ff[AW-1:0];
               st_link_wdata  = next_ff;
            end
            state_in = S_REM2;
         end

         S_REM2: begin
            // push the freed slot on the free list
            st_ctl.link_we = 1'b1;
            st_wr_addr     = cur_ff[AW-1:0];
            st_link_wdata  = free_head_ff;
            free_head_in   = cur_ff;
            if (held_ff != '0) begin
               held_in = IW'(held_ff - 1'b1);
            end
            status_in = STATUS_OK;
            state_in  = S_DONE;
         end

         S_DONE: begin
            // hold until the result register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_count_in  = COUNT_WIDTH'(held_ff);
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         list_head_ff <= NIL;
         free_head_ff <= '0;
         held_ff      <= '0;
         fill_ff      <= '0;
         order_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         list_head_ff <= list_head_in;
         free_head_ff <= free_head_in;
         held_ff      <= held_in;
         fill_ff      <= fill_in;
         order_ff     <= order_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      value_ff      <= value_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      next_ff       <= next_in;
      steps_ff      <= steps_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.payload.status = rsp_status_ff;
   assign rsp_chan.payload.count  = rsp_count_ff;

   // a taken request always starts work
   a_take_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff != S_IDLE)
      else $error("request transfer did not start the sequencer");

   // the walk only ever sits on a real entry
   a_walk_on_entry: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WALK |-> cur_ff != NIL)
      else $error("walk step on a null index");

   // the count moves only at the commit step of an add or a remove
   a_count_commit: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_INS3 && state_ff != S_REM2) |=> $stable(held_ff))
      else $error("element count changed outside a commit step");

   // an empty free list means every slot is held
   a_free_empty_full: assert property (@(posedge clock) disable iff (reset)
      (free_head_ff == NIL && state_ff != S_INS3) |-> held_ff == NIL)
      else $error("free list empty while slots remain unused");

endmodule

@@ tb/sorted_set_linked_table_test.sv @@
// Self-checking bench for sorted_set_linked_table: a shadow copy of the sorted list
// and free chain predicts every response; directed and random traffic, mostly with idling, drives the block.
// Depends on ssl_pkg, ssl_chan_if and the sorted_set_linked_table RTL.
`timescale 1ns / 100ps

module sorted_set_linked_table_test;
   import ssl_pkg::*;

   localparam int unsigned SLOT_COUNT      = DEFAULT_CAPACITY;
   localparam int unsigned NO_SLOT         = SLOT_COUNT;
   localparam int          WATCHDOG_LIMIT  = 3000;
   localparam int          RSP_HOLD_CYCLES = 400;
   localparam int          END_WAIT_CYCLES = 80;
   localparam int          MAX_PRINTED     = 40;
   localparam int          FILL_LENGTH     = SLOT_COUNT + 6;

   // mode 3 has no meaning; the block answers it as a miss
   localparam logic [MODE_WIDTH-1:0] MODE_UNUSED = 2'd3;

   localparam logic signed [VALUE_WIDTH-1:0] VALUE_MIN = 32'sh8000_0000;
   localparam logic signed [VALUE_WIDTH-1:0] VALUE_MAX = 32'sh7FFF_FFFF;

   typedef logic signed [VALUE_WIDTH-1:0] value_list_type[$];

   typedef struct {
      req_payload_type req;
      rsp_payload_type rsp;
   } answer_type;

   // Shadow of the list held by the block: value and link stores, both chain heads
   // and the element count. Accepted requests go in, expected answers queue up.
   class sorted_set_shadow;
      logic signed [VALUE_WIDTH-1:0] slot_value[SLOT_COUNT];
      int unsigned                   slot_link[SLOT_COUNT];
      int unsigned                   list_head;
      int unsigned                   free_head;
      int unsigned                   held;
      bit                            descending;
      answer_type                    answers[$];
      int                            failures;

      function new();
         for (int unsigned i = 0; i < SLOT_COUNT; i++) begin
            slot_value[i] = '0;
            slot_link[i]  = i + 1;
         end
         list_head  = NO_SLOT;
         free_head  = 0;
         held       = 0;
         descending = 1'b0;
         failures   = 0;
      endfunction

      function int unsigned next_of(int unsigned slot);
         if (slot >= NO_SLOT || slot_link[slot] >= NO_SLOT)
            return NO_SLOT;
         return slot_link[slot];
      endfunction

      // true while a stored value may stay ahead of a new one
      function bit stays_ahead(logic signed [VALUE_WIDTH-1:0] stored,
                               logic signed [VALUE_WIDTH-1:0] incoming);
         return descending ? (stored >= incoming) : (stored <= incoming);
      endfunction

      function logic [STATUS_WIDTH-1:0] insert_value(logic signed [VALUE_WIDTH-1:0] v);
         int unsigned cur, prev, steps, slot;
         cur   = list_head;
         prev  = NO_SLOT;
         steps = 0;
         while (cur < NO_SLOT && steps < SLOT_COUNT && slot_value[cur] != v
                && stays_ahead(slot_value[cur], v)) begin
            prev = cur;
            cur  = next_of(cur);
            steps++;
         end
         if (cur < NO_SLOT && slot_value[cur] == v)
            return STATUS_MISS;
         if (free_head >= NO_SLOT)
            return STATUS_FULL;
         slot             = free_head;
         free_head        = next_of(slot);
         slot_value[slot] = v;
         slot_link[slot]  = cur;
         if (prev >= NO_SLOT)
            list_head = slot;
         else
            slot_link[prev] = slot;
         held++;
         return STATUS_OK;
      endfunction

      function logic [STATUS_WIDTH-1:0] unlink_value(logic signed [VALUE_WIDTH-1:0] v);
         int unsigned cur, prev, steps;
         cur   = list_head;
         prev  = NO_SLOT;
         steps = 0;
         while (cur < NO_SLOT && steps < SLOT_COUNT && slot_value[cur] != v) begin
            prev = cur;
            cur  = next_of(cur);
            steps++;
         end
         if (cur >= NO_SLOT || slot_value[cur] != v)
            return STATUS_MISS;
         if (prev >= NO_SLOT)
            list_head = next_of(cur);
         else
            slot_link[prev] = next_of(cur);
         slot_link[cur] = free_head;
         free_head      = cur;
         if (held > 0)
            held--;
         return STATUS_OK;
      endfunction

      function logic [STATUS_WIDTH-1:0] find_value(logic signed [VALUE_WIDTH-1:0] v);
         int unsigned cur, steps;
         cur   = list_head;
         steps = 0;
         while (cur < NO_SLOT && steps < SLOT_COUNT) begin
            if (slot_value[cur] == v)
               return STATUS_OK;
            cur = next_of(cur);
            steps++;
         end
         return STATUS_MISS;
      endfunction

      function value_list_type held_values();
         value_list_type found;
         int unsigned    cur, steps;
         cur   = list_head;
         steps = 0;
         while (cur < NO_SLOT && steps < SLOT_COUNT) begin
            found.push_back(slot_value[cur]);
            cur = next_of(cur);
            steps++;
         end
         return found;
      endfunction

      function void note_request(req_payload_type req);
         answer_type a;
         a.req = req;
         case (req.mode)
            MODE_ADD:    a.rsp.status = insert_value(req.value);
            MODE_REMOVE: a.rsp.status = unlink_value(req.value);
            MODE_SEARCH: a.rsp.status = find_value(req.value);
            default:     a.rsp.status = STATUS_MISS;
         endcase
         a.rsp.count = COUNT_WIDTH'(held);
         answers.push_back(a);
      endfunction

      function int pending();
         return answers.size();
      endfunction

      task report(string msg);
         failures++;
         if (failures <= MAX_PRINTED)
            $display("[%0t] mismatch: %s", $realtime, msg);
      endtask

      task check_response(rsp_payload_type got);
         answer_type want;
         if (answers.size() == 0) begin
            report($sformatf("response with nothing outstanding: status %0d count %0d",
                             got.status, got.count));
            return;
         end
         want = answers.pop_front();
         if (got.status !== want.rsp.status)
            report($sformatf("mode %0d value %0d: status %0d, predicted %0d",
                             want.req.mode, want.req.value, got.status, want.rsp.status));
         if (got.count !== want.rsp.count)
            report($sformatf("mode %0d value %0d: count %0d, predicted %0d",
                             want.req.mode, want.req.value, got.count, want.rsp.count));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;

   ssl_chan_if #(.payload_type(req_payload_type)) req_chan ();
   ssl_chan_if #(.payload_type(rsp_payload_type)) rsp_chan ();

   sorted_set_linked_table dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan)
   );

   sorted_set_shadow tracker = new();

   // traffic shaping shared by both sides of the block
   bit calm_traffic     = 1'b0;
   int rsp_holds_wanted = 0;
   int rsp_holds_taken  = 0;
   int rsp_hold_left    = 0;
   int idle_cycles      = 0;

   always #2 clock = ~clock;

   // Response side: drive ready at the falling edge. A requested hold-off keeps
   // ready low for a long stretch so the block fills and stalls its input.
   always @(negedge clock) begin
      if (rsp_holds_taken != rsp_holds_wanted) begin
         rsp_holds_taken <= rsp_holds_wanted;
         rsp_hold_left   <= RSP_HOLD_CYCLES;
         rsp_chan.ready  <= 1'b0;
      end else if (rsp_hold_left != 0) begin
         rsp_hold_left  <= rsp_hold_left - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= calm_traffic || ($urandom_range(99) >= 19);
      end
   end

   // Check each response transfer against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         tracker.check_response(rsp_chan.payload);
   end

   // Watchdog: count cycles without any transfer on either channel; give up at the limit.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offer one request; idle first at random unless traffic is calm. Return once
   // the transfer has happened and the shadow has taken it in.
   task automatic send_request(input logic [MODE_WIDTH-1:0] mode,
                               input logic signed [VALUE_WIDTH-1:0] value);
      req_payload_type item;
      item.mode  = mode;
      item.value = value;
      @(negedge clock);
      while (!calm_traffic && $urandom_range(99) < 19) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= item;
      do @(posedge clock); while (!req_chan.ready);
      tracker.note_request(item);
   endtask

   // Drop valid and hold until every predicted response has come back.
   task automatic drain();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (tracker.pending() != 0)
         @(posedge clock);
   endtask

   // Only called with the block idle, so the shadow may switch at the write edge.
   task automatic write_order(input bit descending);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= descending;
      @(posedge clock);
      tracker.descending = descending;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Mostly plain random words, with the extremes, zero and minus one mixed in.
   function automatic logic signed [VALUE_WIDTH-1:0] random_value();
      case ($urandom_range(15))
         0:       return VALUE_MIN;
         1:       return VALUE_MAX;
         2:       return '0;
         3:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // Random mix over a small pool so adds collide and removes hit.
   task automatic random_phase(input int pool_size, input int items, input int add_weight);
      logic signed [VALUE_WIDTH-1:0] pool[$];
      logic signed [VALUE_WIDTH-1:0] v;
      logic [MODE_WIDTH-1:0]         mode;
      int                            pick;
      repeat (pool_size) pool.push_back(random_value());
      repeat (items) begin
         pick = $urandom_range(99);
         if (pick < add_weight)
            mode = MODE_ADD;
         else if (pick < add_weight + 28)
            mode = MODE_REMOVE;
         else if (pick < 95)
            mode = MODE_SEARCH;
         else
            mode = MODE_UNUSED;
         v = ($urandom_range(7) == 0) ? random_value() : pool[$urandom_range(pool_size - 1)];
         send_request(mode, v);
      end
   endtask

   // Empty the set, fill it past capacity, then try a duplicate and a fresh add
   // while full, search for two fill values, and finally remove everything in shuffled order.
   task automatic fill_and_empty();
      value_list_type                current;
      value_list_type                fill;
      logic signed [VALUE_WIDTH-1:0] start, stride, tmp;
      int                            j;
      current = tracker.held_values();
      foreach (current[i])
         send_request(MODE_REMOVE, current[i]);
      start  = $urandom;
      stride = $urandom | 32'd1;
      for (int i = 0; i < FILL_LENGTH; i++) begin
         fill.push_back(start + i * stride);
         send_request(MODE_ADD, fill[i]);
      end
      send_request(MODE_ADD, fill[0]);
      send_request(MODE_ADD, start + FILL_LENGTH * stride);
      send_request(MODE_SEARCH, fill[3]);
      send_request(MODE_SEARCH, fill[FILL_LENGTH - 1]);
      for (int i = FILL_LENGTH - 1; i > 0; i--) begin
         j       = $urandom_range(i);
         tmp     = fill[i];
         fill[i] = fill[j];
         fill[j] = tmp;
      end
      foreach (fill[i])
         send_request(MODE_REMOVE, fill[i]);
   endtask

   initial begin
      reset            = 1'b1;
      csr_wr_en        = 1'b0;
      csr_wr_data      = 1'b0;
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty set, extremes of the value range, duplicates, head
      // and tail removal, misses past the end of the list, unused mode.
      write_order(1'b0);
      send_request(MODE_SEARCH, '0);
      send_request(MODE_REMOVE, 32'sd5);
      send_request(MODE_UNUSED, '0);
      send_request(MODE_ADD, '0);
      send_request(MODE_ADD, VALUE_MIN);
      send_request(MODE_ADD, VALUE_MAX);
      send_request(MODE_ADD, '1);
      send_request(MODE_ADD, 32'sd1);
      send_request(MODE_ADD, '0);
      send_request(MODE_SEARCH, VALUE_MIN);
      send_request(MODE_SEARCH, VALUE_MAX);
      send_request(MODE_SEARCH, '1);
      send_request(MODE_SEARCH, 32'sd2);
      send_request(MODE_REMOVE, VALUE_MAX);
      send_request(MODE_REMOVE, VALUE_MIN);
      send_request(MODE_REMOVE, 32'sd1);
      send_request(MODE_REMOVE, 32'sd7);
      send_request(MODE_ADD, VALUE_MAX - 1);
      send_request(MODE_SEARCH, VALUE_MAX - 1);
      send_request(MODE_SEARCH, VALUE_MAX);
      send_request(MODE_UNUSED, '1);
      drain();

      // Descending with values still held in ascending order; the receiver
      // holds off early on so the block backs up.
      write_order(1'b1);
      rsp_holds_wanted++;
      random_phase(24, 200, 45);
      drain();

      write_order(1'b0);
      random_phase(40, 200, 45);
      fill_and_empty();
      drain();

      write_order(1'b1);
      fill_and_empty();
      drain();

      // Back-to-back traffic without any idling on either side.
      write_order(1'b0);
      calm_traffic = 1'b1;
      random_phase(64, 250, 50);
      calm_traffic = 1'b0;
      drain();

      // A wide pool with heavy adding, so the set runs full.
      write_order(1'b1);
      random_phase(100, 250, 58);
      drain();

      write_order(1'b0);
      random_phase(12, 150, 40);
      drain();

      repeat (END_WAIT_CYCLES) @(posedge clock);
      if (tracker.failures == 0 && tracker.pending() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
